// ===== rtl/sla_pkg.sv =====
// Shared types and constants for the signed lane-sum accumulator.
// Used by the lane, merge and top-level modules; depends on nothing else.
package sla_pkg;

  localparam int IDX_W       = 12;
  localparam int WORD_W      = 32;
  localparam int CODE_W      = 8;
  localparam int NUM_LANES   = 4;
  localparam int SAMPLE_W    = 16;
  localparam int LANE_CODE_W = 2;
  localparam int CONTRIB_W   = SAMPLE_W + 1;
  localparam int LANE_SUM_W  = CONTRIB_W + 2;

  localparam logic [LANE_CODE_W-1:0] LANE_ADD  = 2'd1;
  localparam logic [LANE_CODE_W-1:0] LANE_SUB  = 2'd2;
  localparam logic [LANE_CODE_W-1:0] LANE_BAD  = 2'd3;
  localparam logic [LANE_CODE_W-1:0] LANE_SKIP = 2'd0;

  typedef logic signed [CONTRIB_W-1:0] contrib_t;

  // Merged lane result: act is low for a rejected halfword code.
  typedef struct packed {
    logic              act;
    logic [WORD_W-1:0] delta;
  } delta_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/sla_lane.sv =====
// One sample lane: turns a sample and its 2-bit code into a signed contribution.
// Depends on sla_pkg.
module sla_lane (
  input  logic [sla_pkg::SAMPLE_W-1:0]    sample,
  input  logic [sla_pkg::LANE_CODE_W-1:0] code,
  output sla_pkg::contrib_t               contrib
);
  import sla_pkg::*;

  logic [CONTRIB_W-1:0] wide;

  assign wide = {1'b0, sample};

  always_comb begin
    case (code)
      LANE_ADD: contrib = wide;
      LANE_SUB: contrib = -wide;
      default:  contrib = '0;
    endcase
  end

endmodule

// ===== rtl/sla_merge.sv =====
// Merge stage: adds the lane contributions and decides whether the code acts.
// Depends on sla_pkg.
module sla_merge (
  input  sla_pkg::contrib_t               contrib [sla_pkg::NUM_LANES],
  input  logic                            byte_samples,
  input  logic [sla_pkg::CODE_W-1:0]      code,
  output sla_pkg::delta_t                 result
);
  import sla_pkg::*;

  logic [LANE_SUM_W-1:0] lane_sum;
  logic                  half_ok;

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_sum = lane_sum + {{(LANE_SUM_W-CONTRIB_W){contrib[k][CONTRIB_W-1]}}, contrib[k]};
    end
  end

  // In halfword mode a lane code of 3, any upper code bit, or an all-zero
  // code means the whole item leaves the accumulator alone.
  assign half_ok = (code[7:4] == 4'd0) && (code[1:0] != LANE_BAD) &&
                   (code[3:2] != LANE_BAD) && (code != '0);

  assign result.act   = byte_samples | half_ok;
  assign result.delta = {{(WORD_W-LANE_SUM_W){lane_sum[LANE_SUM_W-1]}}, lane_sum};

endmodule

// ===== rtl/signed_lane_sum_accumulator_unit.sv =====
// Top level of the signed lane-sum accumulator: stream ports, accumulator
// memory, four lanes and the merge stage. Depends on sla_pkg, sla_lane, sla_merge.
//
// The block keeps one 32-bit accumulator per scan position in an internal
// memory of NUM_SCANS words. Each request names a scan position, carries a
// packed detector word and an 8-bit coefficient code, and returns the updated
// accumulator. In accumulate mode four lane units weight the byte or halfword
// samples by +1, -1 or 0 and a merge stage sums them into one delta; in load
// mode the word replaces the accumulator. A request with a scan position at or
// above NUM_SCANS leaves the memory untouched and returns a sum of zero. Each
// request first reads the accumulator from the single-port memory into its read
// register, then adds the delta and writes it back once the output register is
// free. After reset the block clears the memory one word per cycle; s_tready
// stays low meanwhile, while configuration writes are taken at any time. A
// finished result waits in the output register, so the next request can be
// accepted and read while the previous result is still unread.
module signed_lane_sum_accumulator_unit #(
  parameter int unsigned NUM_SCANS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Input request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // scan_index[11:0], packed_word[43:12], coeff_code[51:44]
  input  logic        s_tuser,  // mode (0 accumulate, 1 load)
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // scan_index_out[11:0], sum[43:12]
  // Configuration: byte_samples register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sla_pkg::*;

  localparam int ADDR_W = (NUM_SCANS > 1) ? $clog2(NUM_SCANS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SCANS - 1);

  // Unpacked request fields.
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_word;
  logic [CODE_W-1:0] in_code;
  logic              in_range;

  assign in_idx   = s_tdata[11:0];
  assign in_word  = s_tdata[43:12];
  assign in_code  = s_tdata[51:44];
  assign in_range = ({20'd0, in_idx} < NUM_SCANS);

  // Configuration register; writes must only arrive while idle; unenforced by the block.
  logic byte_samples;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_samples <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      byte_samples <= cfg_data;
    end
  end

  // Lane inputs: in byte mode each lane takes one byte, in halfword mode
  // lanes 0 and 1 take the two halfwords and lanes 2 and 3 are skipped.
  logic [SAMPLE_W-1:0]    lane_sample [NUM_LANES];
  logic [LANE_CODE_W-1:0] lane_code   [NUM_LANES];
  contrib_t               lane_contrib [NUM_LANES];
  delta_t                 in_delta;

  always_comb begin
    if (byte_samples) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        lane_sample[k] = {8'd0, in_word[8*k +: 8]};
        lane_code[k]   = in_code[2*k +: 2];
      end
    end else begin
      lane_sample[0] = in_word[15:0];
      lane_sample[1] = in_word[31:16];
      lane_sample[2] = '0;
      lane_sample[3] = '0;
      lane_code[0]   = in_code[1:0];
      lane_code[1]   = in_code[3:2];
      lane_code[2]   = LANE_SKIP;
      lane_code[3]   = LANE_SKIP;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sla_lane u_lane (
      .sample  (lane_sample[g]),
      .code    (lane_code[g]),
      .contrib (lane_contrib[g])
    );
  end

  sla_merge u_merge (
    .contrib      (lane_contrib),
    .byte_samples (byte_samples),
    .code         (in_code),
    .result       (in_delta)
  );

  // Control state.
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              out_free;
  logic              accept;
  logic              out_load;

  // Request held between read and write-back.
  logic              item_mode;
  logic [IDX_W-1:0]  item_idx;
  logic [ADDR_W-1:0] item_addr;
  logic [WORD_W-1:0] item_word;
  logic              item_in_range;
  delta_t            item_delta;

  // Accumulator memory.
  logic [WORD_W-1:0] accum_mem [NUM_SCANS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] new_sum;

  // Output register.
  logic [IDX_W-1:0]  out_idx;
  logic [WORD_W-1:0] sum_q;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (item_mode) begin
      new_sum = item_word;
    end else if (item_delta.act) begin
      new_sum = rd_data + item_delta.delta;
    end else begin
      new_sum = rd_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output and memory-control logic.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    out_load  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_load  = 1'b1;
          mem_we    = item_in_range;
          mem_waddr = item_addr;
          mem_wdata = new_sum;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // The read is issued on the accept edge and the read register then holds
  // through any output stall; the write-back lands before the next request
  // can be accepted, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      accum_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= accum_mem[ADDR_W'(in_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode     <= s_tuser;
      item_idx      <= in_idx;
      item_addr     <= ADDR_W'(in_idx);
      item_word     <= in_word;
      item_in_range <= in_range;
      item_delta    <= in_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx <= item_idx;
      sum_q   <= item_in_range ? new_sum : '0;
    end
  end

  assign m_tdata = {4'd0, sum_q, out_idx};

  // A scan position outside the store always reports a zero sum.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && !item_in_range) |=> (sum_q == '0))
    else $error("out-of-range request returned a nonzero sum");

  // An in-range load returns exactly the loaded word.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && item_in_range && item_mode) |=> (sum_q == $past(item_word)))
    else $error("load request did not return its word");

  // A code that does not act leaves the stored value as it was read.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && item_in_range && !item_mode && !item_delta.act)
      |=> (sum_q == $past(rd_data)))
    else $error("non-acting code changed the accumulator");

endmodule
